// ===== rtl/ocr_pkg.sv =====
// Shared types, constants and tables for the orbit camera rotate block.
// No dependencies; used by the core and the CORDIC rtl files.
package ocr_pkg;

   localparam int CORDIC_STAGES_DEF    = 16;
   localparam int VECTOR_FRAC_BITS_DEF = 14;
   localparam int ATAN_ENTRIES         = 24;

   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
   localparam logic signed [32:0] DEG_RAD_K   = 33'sd36602;

   // register indexes
   localparam logic [2:0] REG_TARGET_X   = 3'd0;
   localparam logic [2:0] REG_TARGET_Y   = 3'd1;
   localparam logic [2:0] REG_TARGET_Z   = 3'd2;
   localparam logic [2:0] REG_DISTANCE   = 3'd3;
   localparam logic [2:0] REG_START_YAW  = 3'd4;
   localparam logic [2:0] REG_START_ELEV = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANG_Y,
      ST_ANG_E,
      ST_ANG_DONE,
      ST_COR_Y,
      ST_COR_E,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } cordic_res_type;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:    r = 34'sd843314856;
         5'd1:    r = 34'sd497837829;
         5'd2:    r = 34'sd263043836;
         5'd3:    r = 34'sd133525158;
         5'd4:    r = 34'sd67021686;
         5'd5:    r = 34'sd33543515;
         5'd6:    r = 34'sd16775850;
         5'd7:    r = 34'sd8388437;
         5'd8:    r = 34'sd4194282;
         5'd9:    r = 34'sd2097149;
         5'd10:   r = 34'sd1048575;
         5'd11:   r = 34'sd524287;
         5'd12:   r = 34'sd262143;
         5'd13:   r = 34'sd131071;
         5'd14:   r = 34'sd65535;
         5'd15:   r = 34'sd32767;
         5'd16:   r = 34'sd16383;
         5'd17:   r = 34'sd8191;
         5'd18:   r = 34'sd4095;
         5'd19:   r = 34'sd2047;
         5'd20:   r = 34'sd1023;
         5'd21:   r = 34'sd511;
         5'd22:   r = 34'sd255;
         5'd23:   r = 34'sd127;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/orbit_camera_rotate_core.sv =====
// Orbit camera rotate core: angle update, CORDIC trig, vectors and position.
// One item at a time: a new req beat is taken only in idle, once the last result has
// been loaded for rsp, which waits while rsp stalls; the shared CORDIC step unit runs
// for yaw then elevation, then seven products go through one shared multiplier (which
// also scales both angle steps before the CORDIC runs).
// Synchronous active-high reset: targets 0, distance 256, yaw and elevation 0.
module orbit_camera_rotate_core #(
   parameter int CORDIC_STAGES    = ocr_pkg::CORDIC_STAGES_DEF,
   parameter int VECTOR_FRAC_BITS = ocr_pkg::VECTOR_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [16:0] req_yaw_step,
   input  logic signed [16:0] req_elevation_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_pos_x,
   output logic signed [23:0] rsp_pos_y,
   output logic signed [23:0] rsp_pos_z,
   output logic signed [15:0] rsp_back_x,
   output logic signed [15:0] rsp_back_y,
   output logic signed [15:0] rsp_back_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z
);
   import ocr_pkg::*;

   localparam int SH = 30 - VECTOR_FRAC_BITS;
   localparam logic signed [32:0] VRND = 33'sd1 <<< (SH - 1);

   function automatic logic signed [15:0] to_vec(input logic signed [32:0] v);
      logic signed [32:0] r;
      r = (v + VRND) >>> SH;
      if (r > 33'sd32767)       return 16'sh7fff;
      else if (r < -33'sd32768) return 16'sh8000;
      else                      return 16'(r);
   endfunction

   function automatic logic signed [15:0] wrap_yaw(input logic signed [17:0] v);
      if (v >= PI_Q13)       return 16'(v - TWO_PI_Q13);
      else if (v < -PI_Q13)  return 16'(v + TWO_PI_Q13);
      else                   return 16'(v);
   endfunction

   function automatic logic signed [14:0] clamp_elev(input logic signed [17:0] v);
      if (v > HALF_PI_Q13)       return 15'(HALF_PI_Q13);
      else if (v < -HALF_PI_Q13) return 15'(-HALF_PI_Q13);
      else                       return 15'(v);
   endfunction

   function automatic logic signed [23:0] sat_pos(input logic signed [26:0] v);
      if (v > 27'sd8388607)       return 24'sh7fffff;
      else if (v < -27'sd8388608) return 24'sh800000;
      else                        return 24'(v);
   endfunction

   state_type state_ff, state_in;

   logic signed [23:0] tx_ff, ty_ff, tz_ff;
   logic [22:0]        dist_ff;
   logic signed [15:0] yaw_ff, yaw_in;
   logic signed [14:0] elev_ff, elev_in;
   logic signed [16:0] sy_step_ff, se_step_ff;
   logic signed [31:0] cy_ff, sy_ff, ce_ff, se_ff;
   logic signed [31:0] zx_ff, zz_ff, secy_ff, sesy_ff;
   logic signed [23:0] px_ff, py_ff, pz_ff;
   logic [2:0]         mcnt_ff, mcnt_in;
   logic signed [65:0] prod_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] rnd30_full, rnd16_full;
   logic signed [35:0] rnd30;
   logic signed [17:0] rnd16;
   logic signed [26:0] pos_sum_x, pos_sum_y, pos_sum_z;
   logic               cor_start;
   logic signed [15:0] cor_angle;
   cordic_res_type     cor_res;
   logic               rsp_valid_ff, rsp_valid_in, load_out;

   logic signed [23:0] o_px_ff, o_py_ff, o_pz_ff;
   logic signed [15:0] o_bx_ff, o_by_ff, o_bz_ff, o_rx_ff, o_rz_ff;
   logic signed [15:0] o_ux_ff, o_uy_ff, o_uz_ff;

   ocr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cor_angle),
      .res   (cor_res)
   );

   assign rnd30_full = (prod_ff + 66'sd536870912) >>> 30;
   assign rnd16_full = (prod_ff + 66'sd32768) >>> 16;
   assign rnd30      = signed'(rnd30_full[35:0]);
   assign rnd16      = signed'(rnd16_full[17:0]);
   assign pos_sum_x  = 27'(tx_ff) + rnd30[26:0];
   assign pos_sum_y  = 27'(ty_ff) + rnd30[26:0];
   assign pos_sum_z  = 27'(tz_ff) + rnd30[26:0];
   assign cor_angle  = (state_ff == ST_ANG_DONE) ? yaw_ff : 16'(elev_ff);
   assign req_ready  = (state_ff == ST_IDLE);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ANG_Y: begin
            mul_a = 33'(sy_step_ff);
            mul_b = DEG_RAD_K;
         end
         ST_ANG_E: begin
            mul_a = 33'(se_step_ff);
            mul_b = DEG_RAD_K;
         end
         ST_MUL: begin
            case (mcnt_ff)
               3'd0: begin mul_a = 33'(ce_ff); mul_b = 33'(cy_ff); end
               3'd1: begin mul_a = 33'(ce_ff); mul_b = 33'(sy_ff); end
               3'd2: begin mul_a = 33'(se_ff); mul_b = 33'(cy_ff); end
               3'd3: begin mul_a = 33'(se_ff); mul_b = 33'(sy_ff); end
               3'd4: begin mul_a = signed'({10'b0, dist_ff}); mul_b = 33'(zx_ff); end
               3'd5: begin mul_a = signed'({10'b0, dist_ff}); mul_b = 33'(se_ff); end
               3'd6: begin mul_a = signed'({10'b0, dist_ff}); mul_b = 33'(zz_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mcnt_in      = mcnt_ff;
      cor_start    = 1'b0;
      load_out     = 1'b0;
      yaw_in       = yaw_ff;
      elev_in      = elev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (csr_we && csr_index == REG_START_YAW)
         yaw_in = wrap_yaw(18'(signed'(csr_wdata[15:0])));
      if (csr_we && csr_index == REG_START_ELEV)
         elev_in = clamp_elev(18'(signed'(csr_wdata[14:0])));
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ANG_Y;
         end
         ST_ANG_Y: state_in = ST_ANG_E;
         ST_ANG_E: begin
            yaw_in   = wrap_yaw(18'(yaw_ff) + rnd16);
            state_in = ST_ANG_DONE;
         end
         ST_ANG_DONE: begin
            elev_in   = clamp_elev(18'(elev_ff) + rnd16);
            cor_start = 1'b1;
            state_in  = ST_COR_Y;
         end
         ST_COR_Y: begin
            if (cor_res.done) begin
               cor_start = 1'b1;
               state_in  = ST_COR_E;
            end
         end
         ST_COR_E: begin
            if (cor_res.done) begin
               mcnt_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd7) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mcnt_ff      <= '0;
         yaw_ff       <= '0;
         elev_ff      <= '0;
         tx_ff        <= '0;
         ty_ff        <= '0;
         tz_ff        <= '0;
         dist_ff      <= 23'd256;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff      <= mcnt_in;
         yaw_ff       <= yaw_in;
         elev_ff      <= elev_in;
         if (csr_we) begin
            case (csr_index)
               REG_TARGET_X: tx_ff   <= signed'(csr_wdata);
               REG_TARGET_Y: ty_ff   <= signed'(csr_wdata);
               REG_TARGET_Z: tz_ff   <= signed'(csr_wdata);
               REG_DISTANCE: dist_ff <= csr_wdata[22:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_valid && req_ready) begin
         sy_step_ff <= req_yaw_step;
         se_step_ff <= req_elevation_step;
      end
      if (state_ff == ST_COR_Y && cor_res.done) begin
         cy_ff <= cor_res.cos_v;
         sy_ff <= cor_res.sin_v;
      end
      if (state_ff == ST_COR_E && cor_res.done) begin
         ce_ff <= cor_res.cos_v;
         se_ff <= cor_res.sin_v;
      end
      // product of the previous multiplier beat lands here
      if (state_ff == ST_MUL) begin
         case (mcnt_ff)
            3'd1:    zx_ff   <= rnd30[31:0];
            3'd2:    zz_ff   <= rnd30[31:0];
            3'd3:    secy_ff <= rnd30[31:0];
            3'd4:    sesy_ff <= rnd30[31:0];
            3'd5:    px_ff   <= sat_pos(pos_sum_x);
            3'd6:    py_ff   <= sat_pos(pos_sum_y);
            3'd7:    pz_ff   <= sat_pos(pos_sum_z);
            default: ;
         endcase
      end
      if (load_out) begin
         o_px_ff <= px_ff;
         o_py_ff <= py_ff;
         o_pz_ff <= pz_ff;
         o_bx_ff <= to_vec(33'(zx_ff));
         o_by_ff <= to_vec(33'(se_ff));
         o_bz_ff <= to_vec(33'(zz_ff));
         o_rx_ff <= to_vec(33'(sy_ff));
         o_rz_ff <= to_vec(-(33'(cy_ff)));
         o_ux_ff <= to_vec(-(33'(secy_ff)));
         o_uy_ff <= to_vec(33'(ce_ff));
         o_uz_ff <= to_vec(-(33'(sesy_ff)));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = o_px_ff;
   assign rsp_pos_y   = o_py_ff;
   assign rsp_pos_z   = o_pz_ff;
   assign rsp_back_x  = o_bx_ff;
   assign rsp_back_y  = o_by_ff;
   assign rsp_back_z  = o_bz_ff;
   assign rsp_right_x = o_rx_ff;
   assign rsp_right_z = o_rz_ff;
   assign rsp_up_x    = o_ux_ff;
   assign rsp_up_y    = o_uy_ff;
   assign rsp_up_z    = o_uz_ff;

endmodule

// ===== rtl/ocr_cordic.sv =====
// Iterative CORDIC sine/cosine, one rotation step per cycle, Q30.
// Depends on ocr_pkg.
module ocr_cordic #(
   parameter int STAGES = ocr_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    angle,
   output ocr_pkg::cordic_res_type res
);
   import ocr_pkg::*;

   localparam int CW = $clog2(STAGES);

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] a_ff, a_in, a_load;
   logic               neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [31:0] dx, dy;
   logic signed [33:0] step_atan;

   assign dx        = y_ff >>> cnt_ff;
   assign dy        = x_ff >>> cnt_ff;
   assign step_atan = atan_q30(5'(cnt_ff));
   assign a_load    = 34'(angle) <<< 17;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      a_in    = a_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         // fold into [-pi/2, pi/2], flip sign of result
         if (a_load > HALF_PI_Q30) begin
            a_in   = a_load - PI_Q30;
            neg_in = 1'b1;
         end else if (a_load < -HALF_PI_Q30) begin
            a_in   = a_load + PI_Q30;
            neg_in = 1'b1;
         end else begin
            a_in   = a_load;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (a_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            a_in = a_ff - step_atan;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            a_in = a_ff + step_atan;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STAGES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      neg_ff <= neg_in;
   end

   assign res.done  = done_ff;
   assign res.cos_v = neg_ff ? -x_ff : x_ff;
   assign res.sin_v = neg_ff ? -y_ff : y_ff;

endmodule

// ===== rtl/ocr_checker.sv =====
// Port-level checks for orbit_camera_rotate_core, attached by bind.
// No package dependencies.
module ocr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_pos_x,
   input logic signed [15:0] rsp_back_y
);

   // busy after a req beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accepted beat");

   // a result never shows up the cycle after a req beat
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("rsp beat appeared too early");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_back_y))
      else $error("stalled rsp beat changed");

endmodule

bind orbit_camera_rotate_core ocr_checker u_ocr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_pos_x  (rsp_pos_x),
   .rsp_back_y (rsp_back_y)
);
